// ===== sv/graph_depth_first_walk_macros.svh =====
// assertion helpers shared by the walker
`ifndef GRAPH_DEPTH_FIRST_WALK_MACROS_SVH
`define GRAPH_DEPTH_FIRST_WALK_MACROS_SVH

// same-cycle implication, checked out of reset
`define GDFW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define GDFW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/gdfw_pkg.sv =====
package gdfw_pkg;

  localparam int NODE_W = 3;
  localparam int MODE_W = 2;
  localparam int NODE_COUNT_DEF = 8;
  localparam int MAX_DEGREE_DEF = 8;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_ADD_EDGE  = 2'd0;
  localparam mode_t MODE_CLEAR_ALL = 2'd1;
  localparam mode_t MODE_WALK      = 2'd2;
  localparam mode_t MODE_CLR_MARKS = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clr_all;
    logic clr_mark;
    logic add_wr;
    logic start;
    logic cnt_load;
    logic list_rd;
    logic pop_rd;
    logic pop_load;
    logic push;
    logic emit_mid;
    logic emit_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic a_ok;
    logic a_visited;
    logic add_ok;
    logic has_next;
    logic depth_one;
    logic next_ok;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/graph_depth_first_walk.sv =====
// depth-first walker over a small directed graph held as per-node neighbour lists
// input channel (in_valid/in_stall): one request of mode, node_a, node_b
//   add edge appends node_a -> node_b, dropped when the list is full or a node
//   is out of range; clear all empties lists and marks; clear marks keeps lists
// a walk request sends one result per newly visited node in preorder on the
// output channel (out_valid/out_stall), out_last set on the final one; a walk
// from a visited or out-of-range node sends nothing; marks persist across walks
// a walk scans stored edges one at a time through the single neighbour-list
// read port, pushes each newly visited node onto the stack and pops back to
// the parent node when a node's list is exhausted
// one request at a time: in_stall is high until the walk's last result sits
// in the output register; the next request may be taken while it waits
// a stalled receiver freezes the walk at its next result, nothing is lost
// reset (rst_n, synchronous) clears lists, marks and the stack at once; the
// list and stack memories themselves are not cleared
module graph_depth_first_walk #(
  parameter int NODE_COUNT = gdfw_pkg::NODE_COUNT_DEF,
  parameter int MAX_DEGREE = gdfw_pkg::MAX_DEGREE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  gdfw_pkg::mode_t  in_mode,
  input  gdfw_pkg::node_t  in_node_a,
  input  gdfw_pkg::node_t  in_node_b,
  output logic             out_valid,
  input  logic             out_stall,
  output gdfw_pkg::node_t  out_visited_node,
  output logic             out_last
);
  import gdfw_pkg::*;

  `include "graph_depth_first_walk_macros.svh"

  cmd_t cmd;
  sts_t sts;

  gdfw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gdfw_dp #(
    .NODE_COUNT (NODE_COUNT),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_node_a        (in_node_a),
    .in_node_b        (in_node_b),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_visited_node (out_visited_node),
    .out_last         (out_last)
  );

  `GDFW_ASSERT_NOW(a_emit_free, cmd.emit_mid || cmd.emit_last, sts.out_free, "result overwrites a waiting one")
  `GDFW_ASSERT_NOW(a_push_pop, cmd.push, !cmd.pop_rd && !cmd.list_rd, "stack push clashes with another step")
  `GDFW_ASSERT_NEXT(a_walk_busy, in_valid && !in_stall && in_mode == MODE_WALK, in_stall, "walk request not held off")

endmodule

// ===== sv/gdfw_ctrl.sv =====
module gdfw_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  gdfw_pkg::mode_t  in_mode,
  output logic             in_stall,
  input  gdfw_pkg::sts_t   sts,
  output gdfw_pkg::cmd_t   cmd
);
  import gdfw_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ADD_RD = 4'd1;
  localparam logic [3:0] S_ADD_WR = 4'd2;
  localparam logic [3:0] S_START  = 4'd3;
  localparam logic [3:0] S_CNT    = 4'd4;
  localparam logic [3:0] S_STEP   = 4'd5;
  localparam logic [3:0] S_NEXT   = 4'd6;
  localparam logic [3:0] S_POP    = 4'd7;
  localparam logic [3:0] S_END    = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_mode)
            MODE_ADD_EDGE:  state_nxt = S_ADD_RD;
            MODE_CLEAR_ALL: cmd.clr_all = 1'b1;
            MODE_WALK:      state_nxt = S_START;
            default:        cmd.clr_mark = 1'b1;
          endcase
        end
      end
      // count read of the source is in flight
      S_ADD_RD: state_nxt = S_ADD_WR;
      S_ADD_WR: begin
        cmd.add_wr = sts.add_ok;
        state_nxt  = S_IDLE;
      end
      S_START: begin
        if (sts.a_ok && !sts.a_visited) begin
          cmd.start = 1'b1;
          state_nxt = S_CNT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CNT: begin
        cmd.cnt_load = 1'b1;
        state_nxt    = S_STEP;
      end
      S_STEP: begin
        if (sts.has_next) begin
          cmd.list_rd = 1'b1;
          state_nxt   = S_NEXT;
        end else if (sts.depth_one) begin
          state_nxt = S_END;
        end else begin
          cmd.pop_rd = 1'b1;
          state_nxt  = S_POP;
        end
      end
      S_NEXT: begin
        if (sts.next_ok) begin
          // previous pending node goes out before the new one replaces it
          if (sts.out_free) begin
            cmd.push     = 1'b1;
            cmd.emit_mid = 1'b1;
            state_nxt    = S_CNT;
          end
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_POP: begin
        cmd.pop_load = 1'b1;
        state_nxt    = S_STEP;
      end
      S_END: begin
        if (sts.out_free) begin
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/gdfw_dp.sv =====
module gdfw_dp #(
  parameter int NODE_COUNT = gdfw_pkg::NODE_COUNT_DEF,
  parameter int MAX_DEGREE = gdfw_pkg::MAX_DEGREE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  gdfw_pkg::node_t  in_node_a,
  input  gdfw_pkg::node_t  in_node_b,
  input  gdfw_pkg::cmd_t   cmd,
  output gdfw_pkg::sts_t   sts,
  output logic             out_valid,
  input  logic             out_stall,
  output gdfw_pkg::node_t  out_visited_node,
  output logic             out_last
);
  import gdfw_pkg::*;

  localparam int NIW = $clog2(NODE_COUNT);
  localparam int CW  = $clog2(MAX_DEGREE + 1);
  localparam int LAW = $clog2(NODE_COUNT * MAX_DEGREE);
  localparam int DW  = $clog2(NODE_COUNT + 1);
  localparam int SEW = NODE_W + 2 * CW;
  localparam int LDEPTH = NODE_COUNT * MAX_DEGREE;

  node_t a_r;
  node_t b_r;
  logic [NODE_COUNT-1:0] vis_r;
  logic [NODE_COUNT-1:0] cvld_r;

  logic [CW-1:0]     cnt_mem [NODE_COUNT];
  logic [CW-1:0]     cnt_q_r;
  logic              cvq_r;
  node_t             list_mem [LDEPTH];
  node_t             list_q_r;
  logic [SEW-1:0]    stk_mem [NODE_COUNT];
  logic [SEW-1:0]    stk_q_r;

  node_t             top_node_r;
  logic [CW-1:0]     top_idx_r;
  logic [CW-1:0]     top_cnt_r;
  logic [DW-1:0]     depth_r;
  node_t             pend_r;

  logic              out_valid_r;
  node_t             out_node_r;
  logic              out_last_r;

  logic [CW-1:0]     cnt_rd;
  logic [NIW-1:0]    cnt_ra;
  logic [NIW-1:0]    a_idx;
  logic [NIW-1:0]    nxt_idx;
  logic [LAW-1:0]    add_wa;
  logic [LAW-1:0]    list_ra;
  logic [NIW-1:0]    stk_wa;
  logic [NIW-1:0]    stk_ra;
  logic              out_free;

  assign a_idx   = NIW'(a_r);
  assign nxt_idx = NIW'(list_q_r);
  assign cnt_rd  = cvq_r ? cnt_q_r : '0;
  // count port serves the add source, the walk start and each pushed node
  assign cnt_ra  = cmd.push ? nxt_idx : a_idx;
  assign add_wa  = LAW'(a_idx) * LAW'(MAX_DEGREE) + LAW'(cnt_rd);
  assign list_ra = LAW'(NIW'(top_node_r)) * LAW'(MAX_DEGREE) + LAW'(top_idx_r);
  assign stk_wa  = NIW'(depth_r - DW'(1));
  assign stk_ra  = NIW'(depth_r - DW'(2));
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    sts.a_ok      = int'(a_r) < NODE_COUNT;
    sts.a_visited = vis_r[a_idx];
    sts.add_ok    = (int'(a_r) < NODE_COUNT) && (int'(b_r) < NODE_COUNT)
                    && (cnt_rd < CW'(MAX_DEGREE));
    sts.has_next  = top_idx_r < top_cnt_r;
    sts.depth_one = depth_r == DW'(1);
    sts.next_ok   = (int'(list_q_r) < NODE_COUNT) && !vis_r[nxt_idx]
                    && (depth_r < DW'(NODE_COUNT));
    sts.out_free  = out_free;
  end

  // marks and count valid bits clear at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vis_r  <= '0;
      cvld_r <= '0;
    end else begin
      if (cmd.clr_all) begin
        vis_r  <= '0;
        cvld_r <= '0;
      end else if (cmd.clr_mark) begin
        vis_r <= '0;
      end else begin
        if (cmd.start) vis_r[a_idx] <= 1'b1;
        if (cmd.push)  vis_r[nxt_idx] <= 1'b1;
        if (cmd.add_wr) cvld_r[a_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_wr) begin
      cnt_mem[a_idx] <= cnt_rd + CW'(1);
    end
    cnt_q_r <= cnt_mem[cnt_ra];
    cvq_r   <= cvld_r[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.add_wr) begin
      list_mem[add_wa] <= b_r;
    end
    if (cmd.list_rd) begin
      list_q_r <= list_mem[list_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stk_mem[stk_wa] <= {top_node_r, top_idx_r, top_cnt_r};
    end
    if (cmd.pop_rd) begin
      stk_q_r <= stk_mem[stk_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= in_node_a;
      b_r <= in_node_b;
    end
    if (cmd.start) begin
      top_node_r <= a_r;
      top_idx_r  <= '0;
      pend_r     <= a_r;
    end else if (cmd.push) begin
      top_node_r <= list_q_r;
      top_idx_r  <= '0;
      pend_r     <= list_q_r;
    end else if (cmd.list_rd) begin
      top_idx_r <= top_idx_r + CW'(1);
    end else if (cmd.pop_load) begin
      {top_node_r, top_idx_r, top_cnt_r} <= stk_q_r;
    end
    if (cmd.cnt_load) begin
      top_cnt_r <= cnt_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else if (cmd.start) begin
      depth_r <= DW'(1);
    end else if (cmd.push) begin
      depth_r <= depth_r + DW'(1);
    end else if (cmd.pop_rd || cmd.emit_last) begin
      depth_r <= depth_r - DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_mid || cmd.emit_last) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_mid || cmd.emit_last) begin
      out_node_r <= pend_r;
      out_last_r <= cmd.emit_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_visited_node = out_node_r;
  assign out_last         = out_last_r;

endmodule
